### design/button_debounce_multiclick_top_assert.svh
// Assertion macros for the button debounce block.
// Both sample on i_clk and are held off while i_rst_n is low.
`ifndef BUTTON_DEBOUNCE_MULTICLICK_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_MULTICLICK_TOP_ASSERT_SVH

// Same-cycle implication.
`define BDM_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bdm assertion failed");

// Next-cycle implication.
`define BDM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bdm assertion failed");

`endif

### design/bdm_pkg.sv
`timescale 1ns / 1ps
package bdm_pkg;

    localparam int NUM_BUTTONS = 10;

    // Field widths
    localparam int BTN_W    = 4;
    localparam int BTN_CNT_W = BTN_W + 1;
    localparam int PIN_W    = 10;
    localparam int KEY_W    = 2;
    localparam int CLICK_W  = 4;
    localparam int HOLD_W   = 16;

    // Configuration registers
    localparam int DEB_W      = 8;
    localparam int WIN_W      = 12;
    localparam int EN_W       = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [DEB_W-1:0] DEB_RESET = DEB_W'(25);
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(500);
    localparam logic [EN_W-1:0]  EN_RESET  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_WINDOW   = 2'd1,
        CFG_ENABLE   = 2'd2
    } t_cfg_reg;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_EDGE = 1'b1;

    typedef enum logic [KEY_W-1:0] {
        KEY_UP      = 2'd0,
        KEY_PRESSED = 2'd1,
        KEY_MULTI   = 2'd2
    } t_key_state;

endpackage

### design/bdm_channels.sv
`timescale 1ns / 1ps
// Input channel: ticks and pin edges.
interface bdm_in_if import bdm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [BTN_W-1:0] button;
    logic [PIN_W-1:0] pin_levels;

    modport source (output valid, cmd, button, pin_levels, input ready);
    modport sink   (input valid, cmd, button, pin_levels, output ready);
endinterface

// Result channel: one beat per reported click window.
interface bdm_out_if import bdm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BTN_W-1:0]   event_button;
    logic [KEY_W-1:0]   key_state;
    logic [CLICK_W-1:0] click_count;
    logic [HOLD_W-1:0]  hold_ticks;

    modport source (output valid, event_button, key_state, click_count, hold_ticks,
                    input ready);
    modport sink   (input valid, event_button, key_state, click_count, hold_ticks,
                    output ready);
endinterface

// Configuration write channel.
interface bdm_cfg_if import bdm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/button_debounce_multiclick_top.sv
`timescale 1ns / 1ps
// Channel  | Direction | Beat contents
// ---------+-----------+------------------------------------------------------
// i_in     | in        | cmd (tick / pin edge), button, pin_levels
// o_evt    | out       | event_button, key_state, click_count, hold_ticks
// i_cfg    | in        | index (0 debounce, 1 window, 2 enable), data
//
// One beat per cycle sustained while o_evt is not stalled. A beat lands in the
// input register; when the pass runs, the per-button lanes and the three
// shared timers update together in one pass; a reported window end goes to the
// output register.
// i_rst_n (synchronous, active low) clears every timer, every lane and the
// configuration back to 25 / 500 / all enabled.
// A stalled output holds the pass only while the output register is full;
// the input register keeps taking one beat meanwhile. i_cfg is always ready.
`include "button_debounce_multiclick_top_assert.svh"

module button_debounce_multiclick_top import bdm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bdm_in_if.sink       i_in,
    bdm_out_if.source    o_evt,
    bdm_cfg_if.sink      i_cfg
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [DEB_W-1:0] r_cfg_deb;
    logic [WIN_W-1:0] r_cfg_win;
    logic [EN_W-1:0]  r_cfg_en;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_deb <= DEB_RESET;
            r_cfg_win <= WIN_RESET;
            r_cfg_en  <= EN_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_DEBOUNCE: r_cfg_deb <= i_cfg.data[DEB_W-1:0];
                CFG_WINDOW:   r_cfg_win <= i_cfg.data[WIN_W-1:0];
                CFG_ENABLE:   r_cfg_en  <= i_cfg.data[EN_W-1:0];
                default:      ; // drop writes past the register list
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register and handshake
    // ---------------------------------------------------------------
    logic             r_in_valid;
    logic             r_cmd;
    logic [BTN_W-1:0] r_btn;
    logic [PIN_W-1:0] r_levels;
    logic             r_out_valid;
    logic             advance;
    logic             in_take;

    // The pass runs whenever a beat waits and the output register can take a result.
    assign advance    = r_in_valid && (!r_out_valid || o_evt.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd    <= i_in.cmd;
            r_btn    <= i_in.button;
            r_levels <= i_in.pin_levels;
        end
    end

    // ---------------------------------------------------------------
    // Shared timers
    // ---------------------------------------------------------------
    logic [DEB_W-1:0] r_deb_left, n_deb_left;
    logic             r_deb_run,  n_deb_run;
    logic [BTN_W-1:0] r_deb_tgt,  n_deb_tgt;
    logic [WIN_W-1:0] r_win_left, n_win_left;
    logic             r_win_run,  n_win_run;
    logic [BTN_W-1:0] r_win_tgt,  n_win_tgt;
    logic             r_hold_run, n_hold_run;
    logic [BTN_W-1:0] r_hold_tgt, n_hold_tgt;

    logic tick_go;
    logic win_end;
    logic deb_exp;

    assign tick_go = advance && (r_cmd == CMD_TICK);
    // A loaded count of zero expires like a count of one.
    assign win_end = r_win_run && (r_win_left <= WIN_W'(1));
    assign deb_exp = r_deb_run && (r_deb_left <= DEB_W'(1));

    // ---------------------------------------------------------------
    // Per-button lanes
    // ---------------------------------------------------------------
    t_key_state         r_key   [NUM_BUTTONS];
    logic [CLICK_W-1:0] r_press [NUM_BUTTONS];
    logic [HOLD_W-1:0]  r_hold  [NUM_BUTTONS];
    logic [HOLD_W-1:0]  lane_hold1 [NUM_BUTTONS];

    logic [NUM_BUTTONS-1:0] lane_pin_low;
    logic [NUM_BUTTONS-1:0] lane_en;
    logic [NUM_BUTTONS-1:0] lane_exp_low;
    logic [NUM_BUTTONS-1:0] lane_exp_up;
    logic [NUM_BUTTONS-1:0] lane_emit;

    for (genvar gi = 0; gi < NUM_BUTTONS; gi++) begin : g_lane
        localparam logic [BTN_W-1:0] IDX = BTN_W'(gi);

        logic               hold_hit;
        logic               win_hit;
        logic               exp_hit;
        logic [CLICK_W-1:0] press1;
        logic [CLICK_W-1:0] n_press;
        logic [HOLD_W-1:0]  n_hold;
        t_key_state         n_key;

        // Buttons past the pin and enable fields read released and disabled.
        if (gi < PIN_W) begin : g_pin
            assign lane_pin_low[gi] = ~r_levels[gi];
        end else begin : g_no_pin
            assign lane_pin_low[gi] = 1'b0;
        end
        if (gi < EN_W) begin : g_en
            assign lane_en[gi] = r_cfg_en[gi];
        end else begin : g_no_en
            assign lane_en[gi] = 1'b0;
        end

        // Order within a tick: hold count, then window end, then debounce expiry.
        always_comb begin
            hold_hit = r_hold_run && (r_hold_tgt == IDX);
            win_hit  = win_end && (r_win_tgt == IDX);
            exp_hit  = deb_exp && (r_deb_tgt == IDX);

            lane_hold1[gi] = (hold_hit && (r_hold[gi] != '1)) ? r_hold[gi] + HOLD_W'(1)
                                                               : r_hold[gi];
            press1 = win_hit ? '0 : r_press[gi];

            n_key   = r_key[gi];
            n_press = press1;
            n_hold  = lane_hold1[gi];
            if (exp_hit) begin
                if (lane_pin_low[gi]) begin
                    n_key = KEY_PRESSED;
                    if (press1 != '1) begin
                        n_press = press1 + CLICK_W'(1);
                    end
                    n_hold = '0;
                end else if (r_key[gi] == KEY_PRESSED) begin
                    n_key = KEY_UP;
                end
                if (n_press > CLICK_W'(1)) begin
                    n_key = KEY_MULTI;
                end
            end

            lane_exp_low[gi] = exp_hit && lane_pin_low[gi];
            lane_exp_up[gi]  = exp_hit && !lane_pin_low[gi] && (r_key[gi] == KEY_PRESSED);
            lane_emit[gi]    = win_hit && lane_en[gi];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_key[gi]   <= KEY_UP;
                r_press[gi] <= '0;
                r_hold[gi]  <= '0;
            end else if (tick_go) begin
                r_key[gi]   <= n_key;
                r_press[gi] <= n_press;
                r_hold[gi]  <= n_hold;
            end
        end
    end

    // ---------------------------------------------------------------
    // Timer next state
    // ---------------------------------------------------------------
    always_comb begin
        n_deb_left = r_deb_left;
        n_deb_run  = r_deb_run;
        n_deb_tgt  = r_deb_tgt;
        n_win_left = r_win_left;
        n_win_run  = r_win_run;
        n_win_tgt  = r_win_tgt;
        n_hold_run = r_hold_run;
        n_hold_tgt = r_hold_tgt;

        if (r_cmd == CMD_EDGE) begin
            // Restart debounce on this button; edges on absent buttons drop.
            if (BTN_CNT_W'(r_btn) < BTN_CNT_W'(NUM_BUTTONS)) begin
                n_deb_left = r_cfg_deb;
                n_deb_run  = 1'b1;
                n_deb_tgt  = r_btn;
            end
        end else begin
            // A press starts the hold counter, a release while the key reads KEY_PRESSED stops it.
            if (|lane_exp_low) begin
                n_hold_run = 1'b1;
                n_hold_tgt = r_deb_tgt;
            end else if (|lane_exp_up) begin
                n_hold_run = 1'b0;
            end

            if (r_win_run) begin
                if (win_end) begin
                    n_win_run  = 1'b0;
                    n_win_left = '0;
                end else begin
                    n_win_left = r_win_left - WIN_W'(1);
                end
            end
            // Every expiry retargets and restarts the click window.
            if (deb_exp) begin
                n_win_left = r_cfg_win;
                n_win_run  = 1'b1;
                n_win_tgt  = r_deb_tgt;
            end

            if (r_deb_run) begin
                if (deb_exp) begin
                    n_deb_left = '0;
                    n_deb_run  = 1'b0;
                end else begin
                    n_deb_left = r_deb_left - DEB_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_left <= '0;
            r_deb_run  <= 1'b0;
            r_deb_tgt  <= '0;
            r_win_left <= '0;
            r_win_run  <= 1'b0;
            r_win_tgt  <= '0;
            r_hold_run <= 1'b0;
            r_hold_tgt <= '0;
        end else if (advance) begin
            r_deb_left <= n_deb_left;
            r_deb_run  <= n_deb_run;
            r_deb_tgt  <= n_deb_tgt;
            r_win_left <= n_win_left;
            r_win_run  <= n_win_run;
            r_win_tgt  <= n_win_tgt;
            r_hold_run <= n_hold_run;
            r_hold_tgt <= n_hold_tgt;
        end
    end

    // ---------------------------------------------------------------
    // Result select and output register
    // ---------------------------------------------------------------
    logic               emit;
    logic [BTN_W-1:0]   sel_btn;
    logic [KEY_W-1:0]   sel_key;
    logic [CLICK_W-1:0] sel_click;
    logic [HOLD_W-1:0]  sel_hold;

    logic [BTN_W-1:0]   r_evt_btn;
    logic [KEY_W-1:0]   r_evt_key;
    logic [CLICK_W-1:0] r_evt_click;
    logic [HOLD_W-1:0]  r_evt_hold;
    logic               n_out_valid;

    assign emit = tick_go && (|lane_emit);

    // At most one lane is the window target, so an OR of masked lanes selects it.
    always_comb begin
        sel_btn   = '0;
        sel_key   = '0;
        sel_click = '0;
        sel_hold  = '0;
        for (int li = 0; li < NUM_BUTTONS; li++) begin
            if (lane_emit[li]) begin
                sel_btn   = sel_btn   | BTN_W'(li);
                sel_key   = sel_key   | KEY_W'(r_key[li]);
                sel_click = sel_click | r_press[li];
                sel_hold  = sel_hold  | lane_hold1[li];
            end
        end
    end

    always_comb begin
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_evt.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_evt_btn   <= sel_btn;
            r_evt_key   <= sel_key;
            r_evt_click <= sel_click;
            r_evt_hold  <= sel_hold;
        end
    end

    assign o_evt.valid        = r_out_valid;
    assign o_evt.event_button = r_evt_btn;
    assign o_evt.key_state    = r_evt_key;
    assign o_evt.click_count  = r_evt_click;
    assign o_evt.hold_ticks   = r_evt_hold;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `BDM_ASSERT_NOW(a_deb_tgt_present, r_deb_run,
                    BTN_CNT_W'(r_deb_tgt) < BTN_CNT_W'(NUM_BUTTONS))
    `BDM_ASSERT_NOW(a_hold_on_pressed, r_hold_run, r_key[r_hold_tgt] != KEY_UP)
    `BDM_ASSERT_NOW(a_no_overrun, r_out_valid && !o_evt.ready, !advance)
    `BDM_ASSERT_NEXT(a_emit_shows, emit, r_out_valid)

endmodule
